FILE: hw/rtl/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg
// Types and constants shared by the bounded deque cells, chains and top level.
// ----------------------------------------------------------------------------
package bdeq_pkg;

	// request codes
	typedef enum logic [1:0] {
		REQ_INS_FRONT = 2'd0,
		REQ_INS_REAR  = 2'd1,
		REQ_DEL_FRONT = 2'd2,
		REQ_DEL_REAR  = 2'd3
	} req_t;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CAP_W  = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
	localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1;

	typedef logic signed [DATA_W-1:0] data_t;

	// input item
	typedef struct packed {
		req_t  req_type;
		data_t value;
	} in_item_t;

	// result item
	typedef struct packed {
		logic  ok;
		data_t front_value;
		data_t rear_value;
		logic  is_empty;
		logic  is_full;
	} out_item_t;

	// operation applied to a whole chain
	typedef struct packed {
		logic  push;  // shift toward the tail, new item enters at the head
		logic  pop;   // shift toward the head
		logic  put;   // write the new item at the tail position
		data_t value;
	} chain_op_t;

	// per-cell select
	typedef struct packed {
		logic load;
		logic take_prev;
		logic take_next;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/bdeq_cell.sv
// ----------------------------------------------------------------------------
// bdeq_cell
// One storage cell of a chain: loads a new item or takes a neighbor's value.
// ----------------------------------------------------------------------------
module bdeq_cell
	import bdeq_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  data_t      new_val,
	input  data_t      prev_val,
	input  data_t      next_val,
	output data_t      val,
	output data_t      val_next
);

	data_t val_q;

	// next value select
	always_comb begin
		priority if (ctrl.load) begin
			val_next = new_val;
		end else if (ctrl.take_prev) begin
			val_next = prev_val;
		end else if (ctrl.take_next) begin
			val_next = next_val;
		end else begin
			val_next = val_q;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		val_q <= val_next;
	end

	assign val = val_q;

endmodule

FILE: hw/rtl/bdeq_chain.sv
// ----------------------------------------------------------------------------
// bdeq_chain
// Row of cells ordered from one end of the deque; the head cell's next value is read out.
// ----------------------------------------------------------------------------
module bdeq_chain
	import bdeq_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  chain_op_t                op,
	input  logic [$clog2(DEPTH)-1:0] tail_idx,
	output data_t                    head_next
);

	localparam int unsigned IDX_W = $clog2(DEPTH);

	data_t vals [DEPTH];
	data_t nexts[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		data_t      prev_val;
		data_t      next_val;

		// neighbor wiring, the ends see their own value
		if (i == 0) begin : g_first
			assign prev_val = vals[i];
		end else begin : g_mid_prev
			assign prev_val = vals[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_val = vals[i];
		end else begin : g_mid_next
			assign next_val = vals[i+1];
		end

		// per-cell decode of the chain operation
		always_comb begin
			ctrl.load      = (op.push && (i == 0)) ||
			                 (op.put && (tail_idx == IDX_W'(i)));
			ctrl.take_prev = op.push && (i != 0);
			ctrl.take_next = op.pop;
		end

		bdeq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.new_val  (op.value),
			.prev_val (prev_val),
			.next_val (next_val),
			.val      (vals[i]),
			.val_next (nexts[i])
		);
	end

	assign head_next = nexts[0];

endmodule

FILE: hw/rtl/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Bounded deque of signed 32-bit values held in two rows of shifting cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | in_item  (req_type, value)
//  out     | from block| out_valid/out_stall| out_item (ok, front, rear, flags)
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_data (capacity)
//
//  One request is taken per cycle while in_stall is low; its result appears in
//  the output register on the next cycle. Both chains update in the same edge, so
//  nothing limits the rate below one item per cycle besides the output register.
//  While a result waits under out_stall, in_stall is raised.
//  Reset clears the entry count and sets capacity to 64; cells hold no reset.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue
	import bdeq_pkg::*;
#(
	parameter int unsigned DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic [CAP_W-1:0] cap_q;
	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] cnt_next_ext;
	logic             accept;
	logic             can_ins;
	logic             can_del;
	logic             ok;
	chain_op_t        front_op;
	chain_op_t        rear_op;
	data_t            front_head;
	data_t            rear_head;
	logic             out_valid_q;
	out_item_t        out_item_q;

	// handshakes
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// capacity clamped to the cell count
	always_comb begin
		cap_eff = CMP_W'(cap_q);
		if (cap_eff > DEPTH_C) begin
			cap_eff = DEPTH_C;
		end
	end

	assign cnt_ext = CMP_W'(cnt_q);
	assign can_ins = cnt_ext < cap_eff;
	assign can_del = cnt_q != '0;

	// request decode into chain operations
	always_comb begin
		front_op       = '0;
		rear_op        = '0;
		front_op.value = in_item.value;
		rear_op.value  = in_item.value;
		ok             = 1'b0;
		cnt_next       = cnt_q;
		unique case (in_item.req_type)
			REQ_INS_FRONT: begin
				ok            = can_ins;
				front_op.push = can_ins;
				rear_op.put   = can_ins;
				if (can_ins) cnt_next = cnt_q + 1'b1;
			end
			REQ_INS_REAR: begin
				ok            = can_ins;
				rear_op.push  = can_ins;
				front_op.put  = can_ins;
				if (can_ins) cnt_next = cnt_q + 1'b1;
			end
			REQ_DEL_FRONT: begin
				ok           = can_del;
				front_op.pop = can_del;
				if (can_del) cnt_next = cnt_q - 1'b1;
			end
			REQ_DEL_REAR: begin
				ok          = can_del;
				rear_op.pop = can_del;
				if (can_del) cnt_next = cnt_q - 1'b1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (!accept) begin
			front_op.push = 1'b0;
			front_op.pop  = 1'b0;
			front_op.put  = 1'b0;
			rear_op.push  = 1'b0;
			rear_op.pop   = 1'b0;
			rear_op.put   = 1'b0;
			cnt_next      = cnt_q;
		end
	end

	// front chain holds the deque from the front, rear chain from the rear
	bdeq_chain #(.DEPTH(DEPTH)) u_front_chain (
		.clk       (clk),
		.op        (front_op),
		.tail_idx  (cnt_q[IDX_W-1:0]),
		.head_next (front_head)
	);

	bdeq_chain #(.DEPTH(DEPTH)) u_rear_chain (
		.clk       (clk),
		.op        (rear_op),
		.tail_idx  (cnt_q[IDX_W-1:0]),
		.head_next (rear_head)
	);

	assign cnt_next_ext = CMP_W'(cnt_next);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			out_item_q.ok          <= ok;
			out_item_q.front_value <= (cnt_next == '0) ? EMPTY_MARK : front_head;
			out_item_q.rear_value  <= (cnt_next == '0) ? EMPTY_MARK : rear_head;
			out_item_q.is_empty    <= cnt_next == '0;
			out_item_q.is_full     <= cnt_next_ext >= cap_eff;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
